/* src/m3i_pkg.sv */
// m3i_pkg: widths, types and cofactor index table for the 3x3 matrix inverse.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package m3i_pkg;

    localparam int ELEM_W    = 32;             // element width, signed Q16.16
    localparam int FRAC_BITS = 16;
    localparam int SCALE     = 2 * FRAC_BITS;  // numerator pre-shift
    localparam int TOL_W     = 16;
    localparam int N_ELEM    = 9;
    localparam int N_ROW     = 3;

    localparam int PROD_W  = 2 * ELEM_W;            // element product
    localparam int ADJ_W   = PROD_W + 1;            // cofactor
    localparam int HI_W    = ADJ_W - ELEM_W;        // upper slice of a cofactor
    localparam int DPART_W = ELEM_W + HI_W;         // partial product for det
    localparam int TERM_W  = ELEM_W + ADJ_W;        // a * cofactor
    localparam int DET_W   = TERM_W + 1;            // sum of three terms
    localparam int MAG_W   = ELEM_W + PROD_W;       // |det|
    localparam int NUM_W   = PROD_W + SCALE;        // |adj| << SCALE
    localparam int Q_W     = ELEM_W + 1;            // quotient bits kept
    localparam int CMP_W   = MAG_W + Q_W;           // divider compare width

    localparam int FRONT_LAT = 6;
    localparam int LANE_LAT  = Q_W + 2;
    localparam int MERGE_LAT = 1;
    localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT + MERGE_LAT;

    // cofactor i = m[A]*m[B] - m[C]*m[D], row-major element indexes
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef logic signed [ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             neg;
        logic             sing;
    } t_lane_in;

    typedef struct packed {
        logic [ELEM_W-1:0] val;
        logic              sat;
        logic              sing;
    } t_lane_out;

    typedef struct packed {
        logic [N_ELEM-1:0][ELEM_W-1:0] val;
        logic                          singular;
        logic                          saturated;
    } t_result;

endpackage

/* src/m3i_if.sv */
// m3i_in_if / m3i_out_if: valid/ready channels carrying a matrix request and its inverse.
// Depends on m3i_pkg.
`timescale 1ns / 1ps

interface m3i_in_if;
    logic valid;
    logic ready;
    logic signed [m3i_pkg::ELEM_W-1:0] in_r0c0, in_r0c1, in_r0c2;
    logic signed [m3i_pkg::ELEM_W-1:0] in_r1c0, in_r1c1, in_r1c2;
    logic signed [m3i_pkg::ELEM_W-1:0] in_r2c0, in_r2c1, in_r2c2;

    modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                    in_r2c0, in_r2c1, in_r2c2, input ready);
    modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3i_out_if;
    logic valid;
    logic ready;
    logic signed [m3i_pkg::ELEM_W-1:0] out_r0c0, out_r0c1, out_r0c2;
    logic signed [m3i_pkg::ELEM_W-1:0] out_r1c0, out_r1c1, out_r1c2;
    logic signed [m3i_pkg::ELEM_W-1:0] out_r2c0, out_r2c1, out_r2c2;
    logic singular;
    logic saturated;

    modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                    out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                    input ready);
    modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                  out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                  output ready);
endinterface

/* src/m3i_front.sv */
// m3i_front: cofactors, determinant, singular test and per-lane divider operands.
// Depends on m3i_pkg. Six register stages, advancing on i_en.
`timescale 1ns / 1ps

module m3i_front (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  m3i_pkg::t_elem                 i_a    [m3i_pkg::N_ELEM],
    input  logic [m3i_pkg::TOL_W-1:0]      i_tol,
    output m3i_pkg::t_lane_in              o_lane [m3i_pkg::N_ELEM],
    output logic [m3i_pkg::MAG_W-1:0]      o_dabs
);

    logic signed [m3i_pkg::PROD_W-1:0]  r_pa    [m3i_pkg::N_ELEM];
    logic signed [m3i_pkg::PROD_W-1:0]  r_pb    [m3i_pkg::N_ELEM];
    logic signed [m3i_pkg::ADJ_W-1:0]   r_adj_b [m3i_pkg::N_ELEM];
    logic signed [m3i_pkg::ADJ_W-1:0]   r_adj_c [m3i_pkg::N_ELEM];
    logic signed [m3i_pkg::ADJ_W-1:0]   r_adj_d [m3i_pkg::N_ELEM];
    logic signed [m3i_pkg::ADJ_W-1:0]   r_adj_e [m3i_pkg::N_ELEM];
    m3i_pkg::t_elem                     r_a0    [m3i_pkg::N_ROW];
    m3i_pkg::t_elem                     r_a1    [m3i_pkg::N_ROW];
    logic signed [m3i_pkg::DPART_W-1:0] r_ph    [m3i_pkg::N_ROW];
    logic signed [m3i_pkg::DPART_W-1:0] r_pl    [m3i_pkg::N_ROW];
    logic signed [m3i_pkg::TERM_W-1:0]  r_term  [m3i_pkg::N_ROW];
    logic signed [m3i_pkg::DET_W-1:0]   r_det;
    m3i_pkg::t_lane_in                  r_lane  [m3i_pkg::N_ELEM];
    logic [m3i_pkg::MAG_W-1:0]          r_dabs;

    logic                               n_det_neg;
    logic signed [m3i_pkg::DET_W-1:0]   n_det_abs;
    logic [m3i_pkg::MAG_W-1:0]          n_dabs;
    logic [m3i_pkg::MAG_W-1:0]          n_tol_sh;
    logic                               n_sing;

    // cofactor products and adjugate
    for (genvar i = 0; i < m3i_pkg::N_ELEM; i++) begin : g_cof
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa[i]    <= i_a[m3i_pkg::COF_IDX[i][0]] * i_a[m3i_pkg::COF_IDX[i][1]];
                r_pb[i]    <= i_a[m3i_pkg::COF_IDX[i][2]] * i_a[m3i_pkg::COF_IDX[i][3]];
                r_adj_b[i] <= m3i_pkg::ADJ_W'(r_pa[i]) - m3i_pkg::ADJ_W'(r_pb[i]);
                r_adj_c[i] <= r_adj_b[i];
                r_adj_d[i] <= r_adj_c[i];
                r_adj_e[i] <= r_adj_d[i];
            end
        end
    end

    // determinant along row 0: cofactor split in hi/lo to keep multipliers narrow
    for (genvar j = 0; j < m3i_pkg::N_ROW; j++) begin : g_det
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a0[j]   <= i_a[j];
                r_a1[j]   <= r_a0[j];
                r_ph[j]   <= r_a1[j] * $signed(r_adj_b[3*j][m3i_pkg::ADJ_W-1:m3i_pkg::ELEM_W]);
                r_pl[j]   <= r_a1[j] * $signed({1'b0, r_adj_b[3*j][m3i_pkg::ELEM_W-1:0]});
                r_term[j] <= (m3i_pkg::TERM_W'(r_ph[j]) <<< m3i_pkg::ELEM_W)
                           + m3i_pkg::TERM_W'(r_pl[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= m3i_pkg::DET_W'(r_term[0]) + m3i_pkg::DET_W'(r_term[1])
                   + m3i_pkg::DET_W'(r_term[2]);
        end
    end

    always_comb begin
        n_det_neg = r_det[m3i_pkg::DET_W-1];
        n_det_abs = n_det_neg ? -r_det : r_det;
        n_dabs    = n_det_abs[m3i_pkg::MAG_W-1:0];
        n_tol_sh  = m3i_pkg::MAG_W'(i_tol) << m3i_pkg::SCALE;
        n_sing    = (n_dabs <= n_tol_sh);
    end

    for (genvar i = 0; i < m3i_pkg::N_ELEM; i++) begin : g_lane
        logic signed [m3i_pkg::ADJ_W-1:0] n_adj_abs;
        assign n_adj_abs = r_adj_e[i][m3i_pkg::ADJ_W-1] ? -r_adj_e[i] : r_adj_e[i];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lane[i].num  <= {n_adj_abs[m3i_pkg::PROD_W-1:0], {m3i_pkg::SCALE{1'b0}}};
                r_lane[i].neg  <= r_adj_e[i][m3i_pkg::ADJ_W-1] ^ n_det_neg;
                r_lane[i].sing <= n_sing;
            end
        end
        assign o_lane[i] = r_lane[i];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dabs <= n_dabs;
        end
    end

    assign o_dabs = r_dabs;

endmodule

/* src/m3i_div_lane.sv */
// m3i_div_lane: pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on m3i_pkg. Input stage, quotient-bit stages, output register; advancing on i_en.
`timescale 1ns / 1ps

module m3i_div_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  m3i_pkg::t_lane_in         i_lane,
    input  logic [m3i_pkg::MAG_W-1:0] i_dabs,
    output m3i_pkg::t_lane_out        o_res
);

    localparam int QW = m3i_pkg::Q_W;
    localparam int EW = m3i_pkg::ELEM_W;

    logic [m3i_pkg::NUM_W-1:0] r_rem  [QW+1];
    logic [QW-1:0]             r_q    [QW+1];
    logic [m3i_pkg::MAG_W-1:0] r_dabs [QW+1];
    logic                      r_ovf  [QW+1];
    logic                      r_neg  [QW+1];
    logic                      r_sing [QW+1];
    m3i_pkg::t_lane_out        r_res;

    logic [QW-1:0]  n_q;
    logic           n_pos_sat;
    logic           n_neg_sat;
    logic [EW-1:0]  n_val;

    // quotient must fit below 2^Q_W, otherwise it saturates anyway
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_lane.num;
            r_q[0]    <= '0;
            r_dabs[0] <= i_dabs;
            r_ovf[0]  <= m3i_pkg::CMP_W'(i_lane.num) >= (m3i_pkg::CMP_W'(i_dabs) << QW);
            r_neg[0]  <= i_lane.neg;
            r_sing[0] <= i_lane.sing;
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_stage
        localparam int K = QW - s;
        logic [m3i_pkg::CMP_W-1:0] n_dsh;
        logic                      n_ge;
        assign n_dsh = m3i_pkg::CMP_W'(r_dabs[s-1]) << K;
        assign n_ge  = m3i_pkg::CMP_W'(r_rem[s-1]) >= n_dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_ge ? r_rem[s-1] - n_dsh[m3i_pkg::NUM_W-1:0] : r_rem[s-1];
                r_q[s]    <= r_q[s-1] | (QW'(n_ge) << K);
                r_dabs[s] <= r_dabs[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_sing[s] <= r_sing[s-1];
            end
        end
    end

    // clip to signed element range
    always_comb begin
        n_q       = r_q[QW];
        n_pos_sat = !r_neg[QW] && (r_ovf[QW] || n_q > {2'b00, {(EW-1){1'b1}}});
        n_neg_sat = r_neg[QW] && (r_ovf[QW] || n_q > {2'b01, {(EW-1){1'b0}}});
        if (n_pos_sat) begin
            n_val = {1'b0, {(EW-1){1'b1}}};
        end else if (n_neg_sat) begin
            n_val = {1'b1, {(EW-1){1'b0}}};
        end else if (r_neg[QW]) begin
            n_val = -n_q[EW-1:0];
        end else begin
            n_val = n_q[EW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.val  <= n_val;
            r_res.sat  <= n_pos_sat || n_neg_sat;
            r_res.sing <= r_sing[QW];
        end
    end

    assign o_res = r_res;

endmodule

/* src/m3i_merge.sv */
// m3i_merge: combines the nine lane results into one inverse request with flags.
// Depends on m3i_pkg. One register stage, advancing on i_en.
`timescale 1ns / 1ps

module m3i_merge (
    input  logic                i_clk,
    input  logic                i_en,
    input  m3i_pkg::t_lane_out  i_res [m3i_pkg::N_ELEM],
    output m3i_pkg::t_result    o_data
);

    m3i_pkg::t_result r_data;
    m3i_pkg::t_result n_data;

    always_comb begin
        n_data.singular  = i_res[0].sing;
        n_data.saturated = 1'b0;
        for (int i = 0; i < m3i_pkg::N_ELEM; i++) begin
            n_data.val[i]    = i_res[0].sing ? '0 : i_res[i].val;
            n_data.saturated = n_data.saturated | (i_res[i].sat & ~i_res[0].sing);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

/* src/matrix_3x3_inverse.sv */
// matrix_3x3_inverse: top level of the 3x3 fixed-point matrix inverse.
// Depends on m3i_pkg, m3i_if, m3i_front, m3i_div_lane, m3i_merge.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake      | contents
//  ---------+-----+----------------+--------------------------------------------
//  i_in     | in  | valid/ready    | nine Q16.16 elements, row-major
//  o_out    | out | valid/ready    | nine Q16.16 inverse elements, singular, saturated
//  i_cfg_*  | in  | write enable   | singular_tolerance (unsigned Q0.16 magnitude)
//
//  One request per cycle while the skid is empty; results leave via the output
//  register. The depth is set by the divider lanes: one quotient bit per stage.
//  Reset (synchronous, active low) empties the pipeline, sets the tolerance to 1 LSB.
//  A full output register holds a result while the next one lands in a skid
//  register; only with the skid full does the pipeline stall and i_in.ready drop.

module matrix_3x3_inverse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    m3i_in_if.sink                        i_in,
    m3i_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [m3i_pkg::TOL_W-1:0]     i_cfg_wdata
);

    localparam int LAT = m3i_pkg::PIPE_LAT;

    logic [m3i_pkg::TOL_W-1:0] r_tol;
    logic [LAT-1:0]            r_vld;
    logic                      r_ov;
    logic                      r_sv;
    m3i_pkg::t_result          r_od;
    m3i_pkg::t_result          r_sd;

    logic                      w_en;
    m3i_pkg::t_elem            w_a    [m3i_pkg::N_ELEM];
    m3i_pkg::t_lane_in         w_lane [m3i_pkg::N_ELEM];
    m3i_pkg::t_lane_out        w_res  [m3i_pkg::N_ELEM];
    logic [m3i_pkg::MAG_W-1:0] w_dabs;
    m3i_pkg::t_result          w_merge;

    // whole pipeline moves together; it stops only when the skid is occupied
    assign w_en       = !r_sv;
    assign i_in.ready = w_en;

    assign w_a[0] = i_in.in_r0c0;
    assign w_a[1] = i_in.in_r0c1;
    assign w_a[2] = i_in.in_r0c2;
    assign w_a[3] = i_in.in_r1c0;
    assign w_a[4] = i_in.in_r1c1;
    assign w_a[5] = i_in.in_r1c2;
    assign w_a[6] = i_in.in_r2c0;
    assign w_a[7] = i_in.in_r2c1;
    assign w_a[8] = i_in.in_r2c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= m3i_pkg::TOL_W'(1);
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    m3i_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (w_a),
        .i_tol  (r_tol),
        .o_lane (w_lane),
        .o_dabs (w_dabs)
    );

    // one divider lane per matrix element
    for (genvar i = 0; i < m3i_pkg::N_ELEM; i++) begin : g_lane
        m3i_div_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lane (w_lane[i]),
            .i_dabs (w_dabs),
            .o_res  (w_res[i])
        );
    end

    m3i_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_res  (w_res),
        .o_data (w_merge)
    );

    // request valid tracking alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // output register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (o_out.ready) begin
                r_ov <= 1'b1;
                r_od <= r_sd;
                r_sv <= 1'b0;
            end
        end else if (r_vld[LAT-1]) begin
            if (!r_ov || o_out.ready) begin
                r_ov <= 1'b1;
                r_od <= w_merge;
            end else begin
                r_sv <= 1'b1;
                r_sd <= w_merge;
            end
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_r0c0  = r_od.val[0];
    assign o_out.out_r0c1  = r_od.val[1];
    assign o_out.out_r0c2  = r_od.val[2];
    assign o_out.out_r1c0  = r_od.val[3];
    assign o_out.out_r1c1  = r_od.val[4];
    assign o_out.out_r1c2  = r_od.val[5];
    assign o_out.out_r2c0  = r_od.val[6];
    assign o_out.out_r2c1  = r_od.val[7];
    assign o_out.out_r2c2  = r_od.val[8];
    assign o_out.singular  = r_od.singular;
    assign o_out.saturated = r_od.saturated;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a request while output register is empty");

    a_stall_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> !i_in.ready)
        else $error("input accepted with skid full");

    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_sv && r_vld[LAT-1] && r_ov && !o_out.ready) |=> r_sv)
        else $error("pipeline result lost at blocked output");

    a_singular_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.singular) |-> !o_out.saturated)
        else $error("singular result flagged as saturated");

endmodule

/* tb/m3i_tb_scoreboard.sv */
// m3i_tb_scoreboard: predicts the inverse of each accepted matrix request and checks results.
// Depends on m3i_pkg.
`timescale 1ns / 1ps

class m3i_inverse_scoreboard;
    typedef logic signed [m3i_pkg::ELEM_W-1:0] elem_t;

    typedef struct {
        elem_t val[9];
        bit    singular;
        bit    saturated;
    } inverse_t;

    inverse_t       pending[$];
    logic [15:0]    tolerance;
    int             n_errors;

    function new();
        tolerance = 16'd1;
        n_errors  = 0;
    endfunction

    // Exact adjugate / determinant, then per-element quotient with clipping.
    function void note_matrix(input elem_t m[9]);
        logic signed [255:0] a[9];
        logic signed [255:0] adj[9];
        logic signed [255:0] det, dabs, num, q, tol_w;
        logic signed [255:0] lim_pos, lim_neg;
        inverse_t            r;
        bit                  neg;
        for (int i = 0; i < 9; i++) a[i] = m[i];
        adj[0] = a[4] * a[8] - a[5] * a[7];
        adj[1] = a[2] * a[7] - a[1] * a[8];
        adj[2] = a[1] * a[5] - a[2] * a[4];
        adj[3] = a[5] * a[6] - a[3] * a[8];
        adj[4] = a[0] * a[8] - a[2] * a[6];
        adj[5] = a[2] * a[3] - a[0] * a[5];
        adj[6] = a[3] * a[7] - a[4] * a[6];
        adj[7] = a[1] * a[6] - a[0] * a[7];
        adj[8] = a[0] * a[4] - a[1] * a[3];
        det  = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        dabs = det < 0 ? -det : det;
        tol_w = 256'(tolerance) << (2 * m3i_pkg::FRAC_BITS);
        r.singular  = 0;
        r.saturated = 0;
        if (dabs <= tol_w) begin
            r.singular = 1;
            for (int i = 0; i < 9; i++) r.val[i] = '0;
        end else begin
            lim_pos = 256'sd2147483647;
            lim_neg = 256'sd2147483648;
            for (int i = 0; i < 9; i++) begin
                num = (adj[i] < 0 ? -adj[i] : adj[i]) << (2 * m3i_pkg::FRAC_BITS);
                neg = (adj[i] < 0) != (det < 0);
                q = num / dabs;
                if (!neg && q > lim_pos) begin
                    r.val[i] = 32'h7FFF_FFFF;
                    r.saturated = 1;
                end else if (neg && q > lim_neg) begin
                    r.val[i] = 32'h8000_0000;
                    r.saturated = 1;
                end else begin
                    r.val[i] = neg ? elem_t'(-q) : elem_t'(q);
                end
            end
        end
        pending.push_back(r);
    endfunction

    function void check_inverse(input elem_t v[9], input bit sing, input bit sat);
        inverse_t e;
        if (pending.size() == 0) begin
            $error("unexpected result, nothing pending");
            n_errors++;
            return;
        end
        e = pending.pop_front();
        for (int i = 0; i < 9; i++)
            if (v[i] !== e.val[i]) begin
                $error("out_r%0dc%0d: expected %0d, got %0d", i / 3, i % 3, e.val[i], v[i]);
                n_errors++;
            end
        if (sing !== e.singular) begin
            $error("singular: expected %0d, got %0d", e.singular, sing);
            n_errors++;
        end
        if (sat !== e.saturated) begin
            $error("saturated: expected %0d, got %0d", e.saturated, sat);
            n_errors++;
        end
    endfunction
endclass

/* tb/matrix_3x3_inverse_tb.sv */
// matrix_3x3_inverse_tb: drives random and directed matrices through the inverse
// and checks each result against an exact wide-integer prediction. Depends on m3i_pkg, m3i_if.
`timescale 1ns / 1ps

module matrix_3x3_inverse_tb;

    localparam int WATCHDOG   = 20000;
    localparam int DRAIN_WAIT = m3i_pkg::PIPE_LAT + 20;

    typedef logic signed [m3i_pkg::ELEM_W-1:0] elem_t;

    logic                      clk = 0;
    logic                      rst_n = 0;
    logic                      cfg_we = 0;
    logic [m3i_pkg::TOL_W-1:0] cfg_wdata = '0;

    m3i_in_if  in_ch ();
    m3i_out_if out_ch ();

    matrix_3x3_inverse u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    m3i_inverse_scoreboard inv_board = new();

    // Run control: quiet_tail stops idling, hold_sink forces a long output stall.
    bit quiet_tail = 0;
    bit hold_sink  = 0;
    int idle_cycles = 0;

    initial begin
        in_ch.valid = 0;
        {in_ch.in_r0c0, in_ch.in_r0c1, in_ch.in_r0c2} = '0;
        {in_ch.in_r1c0, in_ch.in_r1c1, in_ch.in_r1c2} = '0;
        {in_ch.in_r2c0, in_ch.in_r2c1, in_ch.in_r2c2} = '0;
        out_ch.ready = 0;
    end

    // ---------------- sender side ----------------
    task automatic send_matrix(input elem_t m[9]);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1;
        in_ch.in_r0c0 <= m[0]; in_ch.in_r0c1 <= m[1]; in_ch.in_r0c2 <= m[2];
        in_ch.in_r1c0 <= m[3]; in_ch.in_r1c1 <= m[4]; in_ch.in_r1c2 <= m[5];
        in_ch.in_r2c0 <= m[6]; in_ch.in_r2c1 <= m[7]; in_ch.in_r2c2 <= m[8];
        // wait for the request to be taken
        do @(posedge clk); while (!in_ch.ready);
        inv_board.note_matrix(m);
    endtask

    task automatic go_idle();
        in_ch.valid <= 0;
        @(posedge clk);
    endtask

    // All results back, then let the pipeline empty before touching the register.
    task automatic drain();
        while (inv_board.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [m3i_pkg::TOL_W-1:0] v);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 0;
        inv_board.tolerance = v;
    endtask

    function automatic elem_t rand_elem(input int kind);
        case (kind)
            0: rand_elem = $urandom;                              // full range
            1: rand_elem = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            2: rand_elem = $signed($urandom_range(0, 32'h3FF)) - 32'sh200;  // tiny
            default: begin
                case ($urandom_range(0, 4))
                    0: rand_elem = 32'h7FFF_FFFF;
                    1: rand_elem = 32'h8000_0000;
                    2: rand_elem = 32'h0001_0000;
                    3: rand_elem = 0;
                    default: rand_elem = -32'sh1_0000;
                endcase
            end
        endcase
    endfunction

    task automatic send_random(input int n);
        elem_t m[9];
        int    kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++)
                m[i] = ($urandom_range(0, 3) == 0) ? rand_elem($urandom_range(0, 3))
                                                    : rand_elem(kind);
            // occasionally make rows dependent so the matrix is singular
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 3; i++) m[6 + i] = m[i];
            send_matrix(m);
        end
    endtask

    task automatic send_rows(input elem_t r0c0, r0c1, r0c2, r1c0, r1c1, r1c2,
                             r2c0, r2c1, r2c2);
        elem_t m[9];
        m = '{r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2};
        send_matrix(m);
    endtask

    localparam elem_t ONE = 32'sh0001_0000;
    localparam elem_t MAXV = 32'sh7FFF_FFFF;
    localparam elem_t MINV = 32'sh8000_0000;

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: identity, scaled, extremes, singular, near-singular, overflow
        send_rows(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        send_rows(2 * ONE, 0, 0, 0, -4 * ONE, 0, 0, 0, ONE / 2);
        send_rows(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_rows(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE, 0, ONE, 0);
        send_rows(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
        send_rows(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV);
        send_rows(MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MINV);
        send_rows(1, 0, 0, 0, 1, 0, 0, 0, 1);
        send_rows(32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, 32'sh100);
        send_rows(2, 0, 0, 0, 2, 0, 0, 0, 32'sh4000_0000);
        send_rows(MAXV, MAXV, 0, MINV, MAXV, 0, 0, 0, 1);
        send_rows(-ONE, ONE, 3, 7, -5, ONE, 2, 9, -ONE);
        send_rows(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                  32'hEDCB_A987, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1, MINV);
        go_idle();
        drain();

        // tolerance extremes, singularity boundary
        write_tolerance(16'hFFFF);
        send_rows(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        send_rows(32'sh100_0000, 0, 0, 0, 32'sh100_0000, 0, 0, 0, 32'sh100_0000);
        send_rows(32'shFF_0000, 0, 0, 0, ONE, 0, 0, 0, ONE);
        send_rows(32'shFF_FF00, 0, 0, 0, ONE, 0, 0, 0, ONE);
        send_random(200);
        go_idle();
        drain();

        write_tolerance(16'h0000);
        send_rows(1, 0, 0, 0, 1, 0, 0, 0, 1);
        send_rows(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_random(300);
        go_idle();
        drain();

        // long output stall while requests keep coming
        hold_sink = 1;
        fork
            send_random(100);
            begin
                repeat (300) @(posedge clk);
                hold_sink = 0;
            end
        join
        go_idle();
        drain();

        write_tolerance(16'h1234);
        send_random(300);
        go_idle();
        drain();

        write_tolerance(16'h0001);
        send_random(330);
        quiet_tail = 1;
        send_random(100);
        go_idle();
        drain();

        if (inv_board.n_errors == 0 && inv_board.pending.size() == 0)
            $display("matrix_3x3_inverse_tb: PASS");
        else
            $display("matrix_3x3_inverse_tb: FAIL");
        $finish;
    end

    // ---------------- receiver side ----------------
    int stall_left = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 0;
        end else if (hold_sink) begin
            out_ch.ready <= 0;
        end else if (quiet_tail) begin
            out_ch.ready <= 1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 0;
        end else if ($urandom_range(0, 6) == 0) begin
            stall_left   <= $urandom_range(0, 8);
            out_ch.ready <= 0;
        end else begin
            out_ch.ready <= 1;
        end
    end

    always @(posedge clk) begin
        elem_t v[9];
        if (rst_n && out_ch.valid && out_ch.ready) begin
            v = '{out_ch.out_r0c0, out_ch.out_r0c1, out_ch.out_r0c2,
                  out_ch.out_r1c0, out_ch.out_r1c1, out_ch.out_r1c2,
                  out_ch.out_r2c0, out_ch.out_r2c1, out_ch.out_r2c2};
            inv_board.check_inverse(v, out_ch.singular, out_ch.saturated);
        end
    end

    // watchdog: cycles with no request moving on either side
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (inv_board.pending.size() == 0 && !in_ch.valid)
                || hold_sink) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("matrix_3x3_inverse_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
endmodule

/* files.f */
src/m3i_pkg.sv
src/m3i_if.sv
src/m3i_front.sv
src/m3i_div_lane.sv
src/m3i_merge.sv
src/matrix_3x3_inverse.sv
tb/m3i_tb_scoreboard.sv
tb/matrix_3x3_inverse_tb.sv
